// ----- rtl/camera_frustum_bounds_assert.svh -----
// Assertion macros used by the port-level checker of the frustum bounds block.
`ifndef CAMERA_FRUSTUM_BOUNDS_ASSERT_SVH
`define CAMERA_FRUSTUM_BOUNDS_ASSERT_SVH

// Same-cycle implication, sampled on clk and muted while arst_n is low.
`define CFB_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("frustum bounds: same-cycle check failed");

// Next-cycle implication, sampled on clk and muted while arst_n is low.
`define CFB_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("frustum bounds: next-cycle check failed");

`endif

// ----- rtl/cfb_pkg.sv -----
// Types, codes and saturation helpers for the frustum bounds block.
package cfb_pkg;

	localparam int PIXEL_BITS    = 14;
	localparam int CFG_DATA_BITS = 16;
	localparam int CFG_IDX_BITS  = 2;
	localparam int QUOT_BITS     = 33;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_FRAME_MODE    = 2'd0,
		REG_DESIGN_WIDTH  = 2'd1,
		REG_DESIGN_HEIGHT = 2'd2
	} cfg_reg_t;

	localparam logic [1:0] FRAME_SCALE  = 2'd0;
	localparam logic [1:0] FRAME_EXTEND = 2'd1;
	localparam logic [1:0] FRAME_BARS   = 2'd2;
	localparam logic [1:0] FIT_AUTO     = 2'd0;
	localparam logic [1:0] FIT_HORIZ    = 2'd1;
	localparam logic [1:0] FIT_VERT     = 2'd2;
	localparam logic       REQ_ORTHO    = 1'b1;

	localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

	typedef struct packed {
		logic                  req_type;
		logic signed [31:0]    lens_or_scale;
		logic signed [31:0]    sensor_width;
		logic signed [31:0]    sensor_height;
		logic [1:0]            fit_mode;
		logic signed [31:0]    shift_horiz;
		logic signed [31:0]    shift_vert;
		logic signed [31:0]    near_dist;
		logic [PIXEL_BITS-1:0] avail_width;
		logic [PIXEL_BITS-1:0] avail_height;
		logic [PIXEL_BITS-1:0] view_width;
		logic [PIXEL_BITS-1:0] view_height;
	} cfb_in_t;

	typedef struct packed {
		logic signed [31:0] bound_left;
		logic signed [31:0] bound_right;
		logic signed [31:0] bound_bottom;
		logic signed [31:0] bound_top;
		logic               div_fault;
	} cfb_out_t;

	// Signed quotient from a magnitude quotient, saturated to 32 bits.
	// A zero divisor gives the extreme of the numerator's sign, or zero.
	function automatic logic signed [31:0] sat_quot(input logic neg, input logic nz,
			input logic dz, input logic ovf, input logic [QUOT_BITS-1:0] q);
		logic [QUOT_BITS-1:0] qn;
		logic signed [31:0]   r;
		qn = ~q + 1'b1;
		if (dz) begin
			r = !nz ? 32'sd0 : (neg ? S32_MIN : S32_MAX);
		end else if (ovf) begin
			r = neg ? S32_MIN : S32_MAX;
		end else if (neg) begin
			r = (q > 33'h0_8000_0000) ? S32_MIN : $signed(qn[31:0]);
		end else begin
			r = (q > 33'h0_7FFF_FFFF) ? S32_MAX : $signed(q[31:0]);
		end
		return r;
	endfunction

	function automatic logic signed [31:0] sat64(input logic signed [63:0] v);
		logic signed [31:0] r;
		if (v > 64'sh0000_0000_7FFF_FFFF) begin
			r = S32_MAX;
		end else if (v < -64'sh0000_0000_8000_0000) begin
			r = S32_MIN;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

endpackage

// ----- rtl/cfb_div.sv -----
// Pipelined restoring divider, one quotient bit per stage, with a side payload.
module cfb_div #(
	parameter int NW = 64,
	parameter int DW = 32,
	parameter int QW = 33,
	parameter int SW = 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_vld,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	input  logic [SW-1:0] side_in,
	output logic          out_vld,
	output logic [QW-1:0] quot,
	output logic          ovf,
	output logic          dz,
	output logic [SW-1:0] side_out
);

	localparam int HW = (NW > QW) ? NW - QW : 1;
	localparam int XW = QW + HW;
	localparam int CW = (HW > DW) ? HW : DW;

	logic [XW-1:0] num_x;
	logic [HW-1:0] hi;
	logic          ovf_in;

	logic          vld_s  [QW+1];
	logic [DW-1:0] rem_s  [QW+1];
	logic [DW-1:0] den_s  [QW+1];
	logic [QW-1:0] lo_s   [QW+1];
	logic [QW-1:0] quot_s [QW+1];
	logic          ovf_s  [QW+1];
	logic [SW-1:0] side_s [QW+1];

	assign num_x  = XW'(num);
	assign hi     = num_x[XW-1:QW];
	// A quotient that needs more than QW bits is flagged up front.
	assign ovf_in = CW'(hi) >= CW'(den);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0]  <= ovf_in ? '0 : DW'(hi);
			den_s[0]  <= den;
			lo_s[0]   <= num_x[QW-1:0];
			quot_s[0] <= '0;
			ovf_s[0]  <= ovf_in;
			side_s[0] <= side_in;
		end
	end

	for (genvar k = 1; k <= QW; k++) begin : g_step
		logic [DW:0] trial;
		logic [DW:0] diff;
		logic        ge;

		assign trial = {rem_s[k-1], lo_s[k-1][QW-1]};
		assign diff  = trial - {1'b0, den_s[k-1]};
		assign ge    = trial >= {1'b0, den_s[k-1]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= vld_s[k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k]  <= ge ? diff[DW-1:0] : trial[DW-1:0];
				den_s[k]  <= den_s[k-1];
				lo_s[k]   <= {lo_s[k-1][QW-2:0], 1'b0};
				quot_s[k] <= {quot_s[k-1][QW-2:0], ge};
				ovf_s[k]  <= ovf_s[k-1];
				side_s[k] <= side_s[k-1];
			end
		end
	end

	assign out_vld  = vld_s[QW];
	assign quot     = quot_s[QW];
	assign ovf      = ovf_s[QW];
	assign dz       = (den_s[QW] == '0);
	assign side_out = side_s[QW];

endmodule

// ----- rtl/camera_frustum_bounds.sv -----
// Near-plane frustum bounds from lens, sensor, fit, shift and viewport data.
// Throughput: one request per cycle unless the output stalls; three chains of 34-stage dividers set the depth.
// A stalled output freezes every stage, so in_ready follows out_ready.
// Reset clears the valid bits and the configuration registers to zero.
module camera_frustum_bounds #(
	parameter int FRAC_BITS = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wr_en,
	input  logic [cfb_pkg::CFG_IDX_BITS-1:0]  cfg_idx,
	input  logic [cfb_pkg::CFG_DATA_BITS-1:0] cfg_wdata,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  cfb_pkg::cfb_in_t               in_data,
	output logic                           out_valid,
	input  logic                           out_ready,
	output cfb_pkg::cfb_out_t              out_data
);

	import cfb_pkg::*;

	localparam int PB  = PIXEL_BITS;
	localparam int RDW = PB + 16;
	localparam int PNW = PB + 34;
	localparam logic [63:0] RND = (64'd1 << FRAC_BITS) - 64'd1;

	typedef struct packed {
		logic                  ortho;
		logic [1:0]            fit;
		logic signed [31:0]    lens;
		logic signed [31:0]    shx;
		logic signed [31:0]    shy;
		logic [PB-1:0]         aw;
		logic [PB-1:0]         ah;
		logic [PB-1:0]         vw;
		logic [PB-1:0]         vh;
		logic [15:0]           dw;
		logic [15:0]           dh;
		logic                  ext;
		logic                  neg;
		logic                  nz;
	} side1_t;

	typedef struct packed {
		logic signed [31:0] ox;
		logic signed [31:0] oy;
		logic signed [31:0] half;
		logic               wide;
		logic               useq;
		logic               fault;
		logic               neg;
		logic               nz;
		logic [1:0]         fit;
		logic [PB-1:0]      vw;
		logic [PB-1:0]      vh;
		logic [RDW-1:0]     rw;
		logic [RDW-1:0]     rh;
		logic               ext;
	} side2_t;

	typedef struct packed {
		logic fault;
		logic neg;
		logic nz;
	} side3_t;

	logic en;

	// Configuration registers.
	logic [1:0]  mode_q;
	logic [15:0] dw_q;
	logic [15:0] dh_q;

	// Stage 1: request capture and first products.
	logic                  vld_s1;
	cfb_in_t               it_s1;
	logic [15:0]           dw_s1;
	logic [15:0]           dh_s1;
	logic                  ext_s1;
	logic signed [63:0]    prod_s1;
	logic [RDW-1:0]        pa_s1;
	logic [RDW-1:0]        pb_s1;
	logic signed [31:0]    sensor;

	logic [63:0]  pneg1;
	logic [31:0]  lmag1;
	side1_t       sd1_in;
	side1_t       sd1;
	logic         rless_in;
	logic         d1_vld;
	logic [QUOT_BITS-1:0] d1_q;
	logic         d1_ovf;
	logic         d1_dz;
	logic [QUOT_BITS-1:0] r_q;
	logic         r_less;

	// Stage 2: frustum size and letterbox rect.
	logic               vld_s2;
	logic signed [31:0] size_s2;
	logic               fault_s2;
	logic               wide_s2;
	logic [1:0]         fit_s2;
	logic signed [31:0] shx_s2;
	logic signed [31:0] shy_s2;
	logic [PB-1:0]      vw_s2;
	logic [PB-1:0]      vh_s2;
	logic [RDW-1:0]     rw_s2;
	logic [RDW-1:0]     rh_s2;
	logic [15:0]        dw_s2;
	logic [15:0]        dh_s2;
	logic               ext_s2;

	// Stage 3: half size and shift products.
	logic [32:0]        hsum;
	logic signed [31:0] half;
	logic               vld_s3;
	logic signed [31:0] half_s3;
	logic signed [48:0] ph_s3;
	logic signed [63:0] px_s3;
	logic signed [63:0] py_s3;
	logic [15:0]        dd_s3;
	logic               wide_s3;
	logic               useq_s3;
	logic               fault_s3;
	logic [1:0]         fit_s3;
	logic [PB-1:0]      vw_s3;
	logic [PB-1:0]      vh_s3;
	logic [RDW-1:0]     rw_s3;
	logic [RDW-1:0]     rh_s3;
	logic               ext_s3;

	logic [48:0]        phn;
	logic signed [63:0] pxr;
	logic signed [63:0] pyr;
	side2_t             sd2_in;
	side2_t             sd2;
	logic               d2_vld;
	logic [QUOT_BITS-1:0] d2_q;
	logic               d2_ovf;
	logic               d2_dz;
	logic signed [31:0] q2s;

	// Stage 4: half extents, extend ratios.
	logic               vld_s4;
	logic signed [31:0] ox_s4;
	logic signed [31:0] oy_s4;
	logic signed [31:0] szx_s4;
	logic signed [31:0] szy_s4;
	logic               fault_s4;
	logic [PB-1:0]      xn_s4;
	logic [PB-1:0]      yn_s4;
	logic [RDW-1:0]     xd_s4;
	logic [RDW-1:0]     yd_s4;
	logic [PB-1:0]      xn;
	logic [PB-1:0]      yn;
	logic [RDW-1:0]     xd;
	logic [RDW-1:0]     yd;

	// Stage 5: raw bounds. Stage 6: scaled numerators.
	logic               vld_s5;
	logic signed [32:0] bnd_s5 [4];
	logic [PB-1:0]      num_s5 [4];
	logic [RDW-1:0]     den_s5 [4];
	logic               fault_s5;
	logic               vld_s6;
	logic signed [PNW-1:0] prd_s6 [4];
	logic [RDW-1:0]     den_s6 [4];
	logic               fault_s6;

	logic               d3_vld;
	logic [QUOT_BITS-1:0] d3_q   [4];
	logic               d3_ovf [4];
	logic               d3_dz  [4];
	side3_t             sd3    [4];

	// Stage 7: output register.
	logic     vld_s7;
	cfb_out_t res_s7;

	assign en        = !vld_s7 || out_ready;
	assign in_ready  = en;
	assign out_valid = vld_s7;
	assign out_data  = res_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= '0;
			dw_q   <= '0;
			dh_q   <= '0;
		end else if (cfg_wr_en) begin
			case (cfg_reg_t'(cfg_idx))
				REG_FRAME_MODE:    mode_q <= cfg_wdata[1:0];
				REG_DESIGN_WIDTH:  dw_q   <= cfg_wdata;
				REG_DESIGN_HEIGHT: dh_q   <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
			vld_s2 <= d1_vld;
			vld_s3 <= vld_s2;
			vld_s4 <= d2_vld;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= d3_vld;
		end
	end

	// ---------------- Stage 1 ----------------
	assign sensor = (in_data.fit_mode inside {FIT_AUTO, FIT_HORIZ}) ?
		in_data.sensor_width : in_data.sensor_height;

	always_ff @(posedge clk) begin
		if (en) begin
			it_s1   <= in_data;
			dw_s1   <= dw_q;
			dh_s1   <= dh_q;
			ext_s1  <= (mode_q == FRAME_EXTEND) && (dh_q != '0);
			prod_s1 <= sensor * in_data.near_dist;
			pa_s1   <= RDW'(in_data.avail_width) * RDW'(dh_q);
			pb_s1   <= RDW'(dw_q) * RDW'(in_data.avail_height);
		end
	end

	assign pneg1 = ~prod_s1 + 1'b1;
	assign lmag1 = it_s1.lens_or_scale[31] ? (~it_s1.lens_or_scale + 1'b1) :
		it_s1.lens_or_scale;
	assign rless_in = pa_s1 < pb_s1;

	always_comb begin
		sd1_in.ortho = (it_s1.req_type == REQ_ORTHO);
		sd1_in.fit   = it_s1.fit_mode;
		sd1_in.lens  = it_s1.lens_or_scale;
		sd1_in.shx   = it_s1.shift_horiz;
		sd1_in.shy   = it_s1.shift_vert;
		sd1_in.aw    = it_s1.avail_width;
		sd1_in.ah    = it_s1.avail_height;
		sd1_in.vw    = it_s1.view_width;
		sd1_in.vh    = it_s1.view_height;
		sd1_in.dw    = dw_s1;
		sd1_in.dh    = dh_s1;
		sd1_in.ext   = ext_s1;
		sd1_in.neg   = prod_s1[63] ^ it_s1.lens_or_scale[31];
		sd1_in.nz    = (prod_s1 != '0);
	end

	cfb_div #(.NW(63), .DW(32), .QW(QUOT_BITS), .SW($bits(side1_t))) u_div_size (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (vld_s1),
		.num      (prod_s1[63] ? pneg1[62:0] : prod_s1[62:0]),
		.den      (lmag1),
		.side_in  (sd1_in),
		.out_vld  (d1_vld),
		.quot     (d1_q),
		.ovf      (d1_ovf),
		.dz       (d1_dz),
		.side_out (sd1)
	);

	// The letterbox rect divides by a nonzero design size whenever it is used.
	cfb_div #(.NW(RDW), .DW(16), .QW(QUOT_BITS), .SW(1)) u_div_rect (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (vld_s1),
		.num      (rless_in ? pa_s1 : pb_s1),
		.den      (rless_in ? dw_s1 : dh_s1),
		.side_in  (rless_in),
		.out_vld  (),
		.quot     (r_q),
		.ovf      (),
		.dz       (),
		.side_out (r_less)
	);

	// ---------------- Stage 2 ----------------
	always_ff @(posedge clk) begin
		if (en) begin
			size_s2  <= sd1.ortho ? sd1.lens : sat_quot(sd1.neg, sd1.nz, d1_dz, d1_ovf, d1_q);
			fault_s2 <= !sd1.ortho && d1_dz;
			if (sd1.fit == FIT_AUTO) begin
				wide_s2 <= sd1.dw > sd1.dh;
			end else begin
				wide_s2 <= (sd1.fit == FIT_HORIZ);
			end
			fit_s2 <= sd1.fit;
			shx_s2 <= sd1.shx;
			shy_s2 <= sd1.shy;
			vw_s2  <= sd1.vw;
			vh_s2  <= sd1.vh;
			rw_s2  <= r_less ? RDW'(sd1.aw) : r_q[RDW-1:0];
			rh_s2  <= r_less ? r_q[RDW-1:0] : RDW'(sd1.ah);
			dw_s2  <= sd1.dw;
			dh_s2  <= sd1.dh;
			ext_s2 <= sd1.ext;
		end
	end

	// ---------------- Stage 3 ----------------
	// Halving truncates toward zero.
	assign hsum = {size_s2[31], size_s2} + {32'd0, size_s2[31]};
	assign half = $signed(hsum[32:1]);

	always_ff @(posedge clk) begin
		if (en) begin
			half_s3  <= half;
			ph_s3    <= half * $signed({1'b0, (wide_s2 ? dh_s2 : dw_s2)});
			px_s3    <= size_s2 * shx_s2;
			py_s3    <= size_s2 * shy_s2;
			dd_s3    <= wide_s2 ? dw_s2 : dh_s2;
			wide_s3  <= wide_s2;
			useq_s3  <= (dh_s2 != '0);
			fault_s3 <= fault_s2;
			fit_s3   <= fit_s2;
			vw_s3    <= vw_s2;
			vh_s3    <= vh_s2;
			rw_s3    <= rw_s2;
			rh_s3    <= rh_s2;
			ext_s3   <= ext_s2;
		end
	end

	assign phn = ~ph_s3 + 1'b1;
	assign pxr = px_s3 + $signed(px_s3[63] ? RND : 64'd0);
	assign pyr = py_s3 + $signed(py_s3[63] ? RND : 64'd0);

	always_comb begin
		sd2_in.ox    = sat64(pxr >>> FRAC_BITS);
		sd2_in.oy    = sat64(pyr >>> FRAC_BITS);
		sd2_in.half  = half_s3;
		sd2_in.wide  = wide_s3;
		sd2_in.useq  = useq_s3;
		sd2_in.fault = fault_s3;
		sd2_in.neg   = ph_s3[48];
		sd2_in.nz    = (ph_s3 != '0);
		sd2_in.fit   = fit_s3;
		sd2_in.vw    = vw_s3;
		sd2_in.vh    = vh_s3;
		sd2_in.rw    = rw_s3;
		sd2_in.rh    = rh_s3;
		sd2_in.ext   = ext_s3;
	end

	cfb_div #(.NW(48), .DW(16), .QW(QUOT_BITS), .SW($bits(side2_t))) u_div_aspect (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (vld_s3),
		.num      (ph_s3[48] ? phn[47:0] : ph_s3[47:0]),
		.den      (dd_s3),
		.side_in  (sd2_in),
		.out_vld  (d2_vld),
		.quot     (d2_q),
		.ovf      (d2_ovf),
		.dz       (d2_dz),
		.side_out (sd2)
	);

	// ---------------- Stage 4 ----------------
	assign q2s = sat_quot(sd2.neg, sd2.nz, d2_dz, d2_ovf, d2_q);

	// Outside extend mode every ratio is one, so the scaling divide passes bounds through.
	always_comb begin
		xn = PB'(1);
		yn = PB'(1);
		xd = RDW'(1);
		yd = RDW'(1);
		if (sd2.ext) begin
			case (sd2.fit)
				FIT_HORIZ: begin
					yn = sd2.vh;
					yd = RDW'(sd2.vw);
				end
				FIT_VERT: begin
					xn = sd2.vw;
					xd = RDW'(sd2.vh);
				end
				default: begin
					xn = sd2.vw;
					xd = sd2.rw;
					yn = sd2.vh;
					yd = sd2.rh;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ox_s4    <= sd2.ox;
			oy_s4    <= sd2.oy;
			if (!sd2.useq) begin
				szx_s4 <= sd2.half;
				szy_s4 <= sd2.half;
			end else if (sd2.wide) begin
				szx_s4 <= sd2.half;
				szy_s4 <= q2s;
			end else begin
				szx_s4 <= q2s;
				szy_s4 <= sd2.half;
			end
			fault_s4 <= sd2.fault || (sd2.useq && d2_dz);
			xn_s4    <= xn;
			yn_s4    <= yn;
			xd_s4    <= xd;
			yd_s4    <= yd;
		end
	end

	// ---------------- Stages 5 and 6 ----------------
	always_ff @(posedge clk) begin
		if (en) begin
			bnd_s5[0] <= $signed({ox_s4[31], ox_s4}) - $signed({szx_s4[31], szx_s4});
			bnd_s5[1] <= $signed({ox_s4[31], ox_s4}) + $signed({szx_s4[31], szx_s4});
			bnd_s5[2] <= $signed({oy_s4[31], oy_s4}) - $signed({szy_s4[31], szy_s4});
			bnd_s5[3] <= $signed({oy_s4[31], oy_s4}) + $signed({szy_s4[31], szy_s4});
			num_s5[0] <= xn_s4;
			num_s5[1] <= xn_s4;
			num_s5[2] <= yn_s4;
			num_s5[3] <= yn_s4;
			den_s5[0] <= xd_s4;
			den_s5[1] <= xd_s4;
			den_s5[2] <= yd_s4;
			den_s5[3] <= yd_s4;
			fault_s5  <= fault_s4;
			fault_s6  <= fault_s5;
		end
	end

	for (genvar i = 0; i < 4; i++) begin : g_lane
		logic [PNW-1:0] pneg;
		side3_t         sd_in;

		always_ff @(posedge clk) begin
			if (en) begin
				prd_s6[i] <= bnd_s5[i] * $signed({1'b0, num_s5[i]});
				den_s6[i] <= den_s5[i];
			end
		end

		assign pneg        = ~prd_s6[i] + 1'b1;
		assign sd_in.fault = (i == 0) ? fault_s6 : 1'b0;
		assign sd_in.neg   = prd_s6[i][PNW-1];
		assign sd_in.nz    = (prd_s6[i] != '0);

		if (i == 0) begin : g_lead
			cfb_div #(.NW(PNW), .DW(RDW), .QW(QUOT_BITS), .SW($bits(side3_t))) u_div_scale (
				.clk      (clk),
				.arst_n   (arst_n),
				.en       (en),
				.in_vld   (vld_s6),
				.num      (prd_s6[i][PNW-1] ? pneg : prd_s6[i]),
				.den      (den_s6[i]),
				.side_in  (sd_in),
				.out_vld  (d3_vld),
				.quot     (d3_q[i]),
				.ovf      (d3_ovf[i]),
				.dz       (d3_dz[i]),
				.side_out (sd3[i])
			);
		end else begin : g_rest
			cfb_div #(.NW(PNW), .DW(RDW), .QW(QUOT_BITS), .SW($bits(side3_t))) u_div_scale (
				.clk      (clk),
				.arst_n   (arst_n),
				.en       (en),
				.in_vld   (vld_s6),
				.num      (prd_s6[i][PNW-1] ? pneg : prd_s6[i]),
				.den      (den_s6[i]),
				.side_in  (sd_in),
				.out_vld  (),
				.quot     (d3_q[i]),
				.ovf      (d3_ovf[i]),
				.dz       (d3_dz[i]),
				.side_out (sd3[i])
			);
		end
	end

	// ---------------- Stage 7 ----------------
	always_ff @(posedge clk) begin
		if (en) begin
			res_s7.bound_left   <= sat_quot(sd3[0].neg, sd3[0].nz, d3_dz[0], d3_ovf[0], d3_q[0]);
			res_s7.bound_right  <= sat_quot(sd3[1].neg, sd3[1].nz, d3_dz[1], d3_ovf[1], d3_q[1]);
			res_s7.bound_bottom <= sat_quot(sd3[2].neg, sd3[2].nz, d3_dz[2], d3_ovf[2], d3_q[2]);
			res_s7.bound_top    <= sat_quot(sd3[3].neg, sd3[3].nz, d3_dz[3], d3_ovf[3], d3_q[3]);
			res_s7.div_fault    <= sd3[0].fault || d3_dz[0] || d3_dz[1] || d3_dz[2] || d3_dz[3];
		end
	end

endmodule

// ----- rtl/cfb_chk.sv -----
// Port-level checker for the frustum bounds block, bound to the top level.
`include "camera_frustum_bounds_assert.svh"

module cfb_chk (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              cfg_wr_en,
	input logic [cfb_pkg::CFG_IDX_BITS-1:0]  cfg_idx,
	input logic [cfb_pkg::CFG_DATA_BITS-1:0] cfg_wdata,
	input logic                              in_valid,
	input logic                              in_ready,
	input cfb_pkg::cfb_in_t                  in_data,
	input logic                              out_valid,
	input logic                              out_ready,
	input cfb_pkg::cfb_out_t                 out_data
);

	// A result waiting without a transfer stays put.
	`CFB_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))

	// With no result pending, or with one being taken, the pipeline always takes a request.
	`CFB_ASSERT_IMP(a_ready_free, !out_valid || out_ready, in_ready)

	// A blocked result freezes the whole pipeline, input side included.
	`CFB_ASSERT_IMP(a_ready_stall, out_valid && !out_ready, !in_ready)

endmodule

bind camera_frustum_bounds cfb_chk u_cfb_chk (.*);
